[rtl/core/sxt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the S-expression tokenizer.
// Depends on nothing; every other file of the block imports it.
package sxt_pkg;

    // Widths fixed by the token format.
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 63;
    localparam int LEN_W   = 7;

    // Default of the longest accepted symbol.
    localparam int SYMBOL_LIMIT_DEF = 64;

    // Result queue between the lexer and the output channel.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // Largest number value; the accumulator sticks here on overflow.
    localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

    // Characters with a meaning of their own.
    localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_OPEN    = 8'h28;
    localparam logic [BYTE_W-1:0] CHAR_CLOSE   = 8'h29;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    // Lexer mode.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_SYMBOL = 2'd2,
        MODE_HALTED = 2'd3
    } t_lex_mode;

    // Token kinds as they appear on the output channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_END      = 3'd0,
        KIND_OPEN     = 3'd1,
        KIND_CLOSE    = 3'd2,
        KIND_NUMBER   = 3'd3,
        KIND_SYM_CHAR = 3'd4,
        KIND_SYM_END  = 3'd5,
        KIND_SYM_LONG = 3'd6
    } t_token_kind;

    // One result as held in the output queue.
    typedef struct packed {
        t_token_kind          kind;
        logic [VALUE_W-1:0]   value;
        logic                 overflowed;
        logic [BYTE_W-1:0]    character;
        logic [LEN_W-1:0]     length;
        logic                 last;
    } t_result;

endpackage

[rtl/core/sxt_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the S-expression tokenizer.
// Depends on sxt_pkg for the field widths.
interface sxt_in_if;
    import sxt_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   input_byte;
    logic                end_of_input;

    modport source (output valid, output input_byte, output end_of_input, input ready);
    modport sink   (input valid, input input_byte, input end_of_input, output ready);
endinterface

interface sxt_out_if;
    import sxt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   token_kind;
    logic [VALUE_W-1:0]  number_value;
    logic                number_overflowed;
    logic [BYTE_W-1:0]   symbol_character;
    logic [LEN_W-1:0]    symbol_length;
    logic                last_of_run;

    modport source (
        output valid, output token_kind, output number_value, output number_overflowed,
        output symbol_character, output symbol_length, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input number_value, input number_overflowed,
        input symbol_character, input symbol_length, input last_of_run, output ready
    );
endinterface

[rtl/core/sexpr_tokenizer.sv]
`timescale 1ns / 1ps
// Latency: with an empty queue, a result is offered in the cycle after its byte is taken.
// Throughput: one input transaction per cycle while the output channel keeps up and each byte
// gives at most one token; a byte that gives two tokens puts both on the output channel in turn, and the
// four-entry result queue sets how far the input side can run ahead of it.
// Reset: synchronous, active low; clears the lexer mode, accumulator, symbol count and queue.
// S-expression tokenizer top level; depends on sxt_pkg and the interfaces in sxt_if.sv.
module sexpr_tokenizer #(
    parameter int SYMBOL_LIMIT = sxt_pkg::SYMBOL_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sxt_in_if.sink      i_in,
    sxt_out_if.source   o_out
);
    import sxt_pkg::*;

    // Lexer state.
    t_lex_mode           r_mode, n_mode;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic                r_sat, n_sat;
    logic [LEN_W-1:0]    r_sym_count, n_sym_count;

    // Result queue.
    t_result             r_queue [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0]   r_fill;

    // Byte decode.
    logic [BYTE_W-1:0]   in_byte;
    logic                eoi, accept, active;
    logic                is_blank, is_paren, is_numeral;
    logic [3:0]          digit;
    logic [VALUE_W+3:0]  acc_times_ten;
    logic                acc_over;
    logic                close_tok, lex_idle, sym_full;

    // Results of this transaction.
    t_result             res_close, res_tail, slot0, slot1;
    logic                v_close, v_tail;
    logic [1:0]          push_cnt;
    logic                pop;

    assign in_byte  = i_in.input_byte;
    assign eoi      = i_in.end_of_input;
    assign i_in.ready = (r_fill <= FILL_W'(FIFO_DEPTH - 2));
    assign accept   = i_in.valid && i_in.ready;
    assign active   = accept && (r_mode != MODE_HALTED);

    assign is_blank = (in_byte == CHAR_SPACE) || (in_byte == CHAR_NEWLINE)
                   || (in_byte == CHAR_TAB);
    assign is_paren = (in_byte == CHAR_OPEN) || (in_byte == CHAR_CLOSE);
    assign is_numeral = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
    assign digit    = 4'(in_byte - CHAR_ZERO);

    // Multiply by ten as two shifts and an add, then add the digit; any bit above the value width means overflow.
    assign acc_times_ten = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                         + {{VALUE_W{1'b0}}, digit};
    assign acc_over      = r_sat || (acc_times_ten[VALUE_W+3:VALUE_W] != 4'd0);

    // A pending number or symbol ends on end of input or on a byte that cannot extend it.
    assign close_tok = active && (
        ((r_mode == MODE_NUMBER) && (eoi || !is_numeral)) ||
        ((r_mode == MODE_SYMBOL) && (eoi || is_blank || is_paren)));
    // The byte is lexed as the start of a new token.
    assign lex_idle  = active && !eoi && ((r_mode == MODE_IDLE) || close_tok);
    assign sym_full  = (r_sym_count >= LEN_W'(SYMBOL_LIMIT));

    // Next lexer state.
    always_comb begin
        n_mode      = r_mode;
        n_acc       = r_acc;
        n_sat       = r_sat;
        n_sym_count = r_sym_count;
        if (active) begin
            if (close_tok || eoi) begin
                n_mode      = MODE_IDLE;
                n_acc       = '0;
                n_sat       = 1'b0;
                n_sym_count = '0;
            end
            if (lex_idle) begin
                if (is_numeral) begin
                    n_mode = MODE_NUMBER;
                    n_acc  = {{(VALUE_W-4){1'b0}}, digit};
                    n_sat  = 1'b0;
                end else if (!is_blank && !is_paren) begin
                    n_mode      = MODE_SYMBOL;
                    n_sym_count = LEN_W'(1);
                end
            end else if (!eoi && (r_mode == MODE_NUMBER)) begin
                n_acc = acc_over ? NUM_MAX : acc_times_ten[VALUE_W-1:0];
                n_sat = acc_over;
            end else if (!eoi && (r_mode == MODE_SYMBOL)) begin
                if (sym_full) begin
                    n_mode = MODE_HALTED;
                end else begin
                    n_sym_count = r_sym_count + LEN_W'(1);
                end
            end
        end
    end

    // Tokens caused by this transaction: the closing token first, then the byte's own.
    always_comb begin
        res_close = '0;
        res_tail  = '0;
        v_close   = 1'b0;
        v_tail    = 1'b0;
        if (close_tok) begin
            v_close = 1'b1;
            if (r_mode == MODE_NUMBER) begin
                res_close.kind       = KIND_NUMBER;
                res_close.value      = r_acc;
                res_close.overflowed = r_sat;
            end else begin
                res_close.kind   = KIND_SYM_END;
                res_close.length = r_sym_count;
            end
        end
        if (active && eoi) begin
            v_tail        = 1'b1;
            res_tail.kind = KIND_END;
        end else if (lex_idle) begin
            priority if (is_blank || is_numeral) begin
                v_tail = 1'b0;
            end else if (in_byte == CHAR_OPEN) begin
                v_tail        = 1'b1;
                res_tail.kind = KIND_OPEN;
            end else if (in_byte == CHAR_CLOSE) begin
                v_tail        = 1'b1;
                res_tail.kind = KIND_CLOSE;
            end else begin
                v_tail             = 1'b1;
                res_tail.kind      = KIND_SYM_CHAR;
                res_tail.character = in_byte;
            end
        end else if (active && (r_mode == MODE_SYMBOL)) begin
            v_tail = 1'b1;
            if (sym_full) begin
                res_tail.kind   = KIND_SYM_LONG;
                res_tail.length = LEN_W'(SYMBOL_LIMIT);
            end else begin
                res_tail.kind      = KIND_SYM_CHAR;
                res_tail.character = in_byte;
                res_tail.length    = r_sym_count;
            end
        end

        // Pack the tokens into consecutive queue slots and mark the final one.
        if (v_close) begin
            slot0    = res_close;
            slot1    = res_tail;
            push_cnt = v_tail ? 2'd2 : 2'd1;
        end else begin
            slot0    = res_tail;
            slot1    = res_tail;
            push_cnt = v_tail ? 2'd1 : 2'd0;
        end
        slot0.last = (push_cnt == 2'd1);
        slot1.last = 1'b1;
    end

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_acc       <= '0;
            r_sat       <= 1'b0;
            r_sym_count <= '0;
        end else begin
            r_mode      <= n_mode;
            r_acc       <= n_acc;
            r_sat       <= n_sat;
            r_sym_count <= n_sym_count;
        end
    end

    // Result queue storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= slot1;
        end
    end

    // Result queue pointers and fill level.
    assign pop = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_fill   <= r_fill + FILL_W'(push_cnt) - FILL_W'(pop);
        end
    end

    // Output channel driven from the queue head.
    assign o_out.valid             = (r_fill != '0);
    assign o_out.token_kind        = r_queue[r_rd_ptr].kind;
    assign o_out.number_value      = r_queue[r_rd_ptr].value;
    assign o_out.number_overflowed = r_queue[r_rd_ptr].overflowed;
    assign o_out.symbol_character  = r_queue[r_rd_ptr].character;
    assign o_out.symbol_length     = r_queue[r_rd_ptr].length;
    assign o_out.last_of_run       = r_queue[r_rd_ptr].last;

    // The queue never holds more entries than it has.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // Once halted, the lexer stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALTED) |=> (r_mode == MODE_HALTED))
        else $error("lexer left the halted mode");

    // A saturated accumulator holds the largest value.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_acc == NUM_MAX))
        else $error("saturation flag without saturated value");

    // In idle mode no token is half gathered.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> ((r_acc == '0) && !r_sat && (r_sym_count == '0)))
        else $error("idle lexer holds token state");

    // Tokens of one byte enter together, so a head that is not last has its successor queued.
    a_run_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_of_run) |-> (r_fill >= FILL_W'(2)))
        else $error("token run split in the result queue");

endmodule
